/* hw/rtl/rwl_pkg.sv */
// Package for the rotated-window least-squares acceleration block.
// Holds window sizing, derived datapath widths and the divider handshake types.
// No dependencies.
package rwl_pkg;

    localparam int NP       = 5;                 // points in the fit window
    localparam int HIST_N   = 3 * NP;            // stored velocity words
    localparam int KW       = $clog2(NP);        // window index width
    localparam int HW       = $clog2(HIST_N);    // history index width
    localparam int VW       = 32;                // velocity / acceleration width
    localparam int STEPW    = 24;                // time step width
    localparam int ROTW     = 16;                // rotation entry width
    localparam int ROT_FRAC = 14;                // fraction bits of rotation entries
    localparam int ROT_HALF = 8192;              // half LSB after the rotation shift
    localparam int ACC_FRAC = 20;                // scale of the slope numerator
    localparam int TW       = STEPW + $clog2(NP);
    localparam int SUMW     = TW + $clog2(NP);
    localparam int DW       = SUMW + 2;          // centered time, signed
    localparam int MULW     = (DW > VW) ? DW + 1 : VW + 1;
    localparam int PW       = 2 * MULW;
    localparam int ACCW     = PW + $clog2(NP) + 1;
    localparam int NUMW     = ACCW + $clog2(NP) + 1 + ACC_FRAC;
    localparam int CW       = NUMW - VW;         // numerator above the quotient bits

    typedef struct packed {
        logic start;
        logic neg;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [VW-1:0] value;
    } div_res_t;

endpackage

/* hw/rtl/rwl_sample_if.sv */
// Input channel of the acceleration block: one velocity sample per transaction.
// Valid/ready handshake. No dependencies.
interface rwl_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [47:0]        rot_row0;
    logic [47:0]        rot_row1;
    logic [47:0]        rot_row2;
    logic [23:0]        time_step;

    modport source (output valid, vel_x, vel_y, vel_z, rot_row0, rot_row1, rot_row2,
                    time_step, input ready);
    modport sink   (input valid, vel_x, vel_y, vel_z, rot_row0, rot_row1, rot_row2,
                    time_step, output ready);
endinterface

/* hw/rtl/rwl_accel_if.sv */
// Output channel of the acceleration block: one acceleration estimate per transaction.
// Valid/ready handshake. No dependencies.
interface rwl_accel_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic               fit_valid;

    modport source (output valid, acc_x, acc_y, acc_z, fit_valid, input ready);
    modport sink   (input valid, acc_x, acc_y, acc_z, fit_valid, output ready);
endinterface

/* hw/rtl/rotated_window_lsq_accel.sv */
// Top level: rotated sliding-window least-squares acceleration estimator.
// Depends on rwl_pkg, rwl_sample_if, rwl_accel_if and rwl_div.
//
//   channel | dir | payload                                       | handshake
//   sample  | in  | vel_x/y/z, rot_row0..2, time_step             | valid/ready
//   accel   | out | acc_x/y/z, fit_valid                          | valid/ready
//
// Each transaction uses the one shared 33x33 multiplier, whose product is registered
// before it is accumulated, and the one-bit-per-cycle divider, which is skipped when
// the time spread is zero.
// Reset clears the velocity and time-step history and the last acceleration.
// A finished result waits in the output register while the next sample is taken;
// the block holds its result only if that register is still full.
module rotated_window_lsq_accel (
    input  logic         clk,
    input  logic         rst_n,
    rwl_sample_if.sink   sample,
    rwl_accel_if.source  accel
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROT, ST_LOAD, ST_DEN, ST_NUM, ST_DIVW, ST_DONE
    } state_t;

    state_t                               state_reg;
    logic signed [rwl_pkg::VW-1:0]        hist_reg [rwl_pkg::HIST_N];
    logic [rwl_pkg::STEPW-1:0]            step_reg [rwl_pkg::NP-1];
    logic signed [rwl_pkg::VW-1:0]        last_reg [3];
    logic signed [rwl_pkg::VW-1:0]        vin_reg  [3];
    logic signed [rwl_pkg::ROTW-1:0]      rot_reg  [9];
    logic signed [rwl_pkg::DW-1:0]        d_reg    [rwl_pkg::NP];
    logic signed [rwl_pkg::PW-1:0]        prod_reg;
    logic signed [rwl_pkg::ACCW-1:0]      acc_reg;
    logic [rwl_pkg::ACCW-1:0]             den_reg;
    logic [rwl_pkg::KW-1:0]               k_reg;
    logic [1:0]                           i_reg;
    logic [1:0]                           j_reg;
    logic                                 ph_reg;
    logic                                 fit_reg;
    logic                                 out_vld_reg;
    logic signed [rwl_pkg::VW-1:0]        ax_reg;
    logic signed [rwl_pkg::VW-1:0]        ay_reg;
    logic signed [rwl_pkg::VW-1:0]        az_reg;
    logic                                 ofit_reg;
    rwl_pkg::div_req_t                    dreq_reg;
    logic [rwl_pkg::ACCW-1:0]             dmag_reg;

    rwl_pkg::div_res_t                    dres;

    logic [rwl_pkg::HW-1:0]               rd_idx;
    logic [rwl_pkg::HW-1:0]               wr_idx;
    logic [3:0]                           rot_idx;
    logic signed [rwl_pkg::VW-1:0]        hist_rd;
    logic signed [rwl_pkg::MULW-1:0]      mul_a;
    logic signed [rwl_pkg::MULW-1:0]      mul_b;
    logic signed [rwl_pkg::ACCW-1:0]      acc_sum;
    logic signed [rwl_pkg::ACCW-1:0]      rnd;
    logic signed [rwl_pkg::VW-1:0]        rot_sat;
    logic [rwl_pkg::ACCW-1:0]             n_mag;
    logic [rwl_pkg::TW-1:0]               t_c [rwl_pkg::NP];
    logic [rwl_pkg::SUMW-1:0]             s_c;
    logic signed [rwl_pkg::DW-1:0]        d_c [rwl_pkg::NP];
    logic                                 k_last;

    // centered sample times from the step history, oldest sample at time zero
    always_comb
    begin
        t_c[0] = '0;
        for (int k = 1; k < rwl_pkg::NP; k++)
        begin
            t_c[k] = t_c[k-1] + rwl_pkg::TW'(step_reg[k-1]);
        end
        s_c = '0;
        for (int k = 0; k < rwl_pkg::NP; k++)
        begin
            s_c = s_c + rwl_pkg::SUMW'(t_c[k]);
        end
        for (int k = 0; k < rwl_pkg::NP; k++)
        begin
            d_c[k] = rwl_pkg::DW'(rwl_pkg::SUMW'(t_c[k]) * rwl_pkg::SUMW'(rwl_pkg::NP))
                   - rwl_pkg::DW'(s_c);
        end
    end

    always_comb
    begin
        rot_idx = 4'(int'(j_reg) * 3 + int'(i_reg));
        wr_idx  = rwl_pkg::HW'(int'(k_reg) * 3 + int'(i_reg));
        k_last  = k_reg == rwl_pkg::KW'(rwl_pkg::NP - 1);
        case (state_reg)
            ST_ROT:  rd_idx = rwl_pkg::HW'((int'(k_reg) - 1) * 3 + int'(j_reg));
            ST_NUM:  rd_idx = rwl_pkg::HW'((rwl_pkg::NP - 1 - int'(k_reg)) * 3 + int'(i_reg));
            default: rd_idx = '0;
        endcase
        hist_rd = hist_reg[rd_idx];

        case (state_reg)
            ST_ROT:
            begin
                mul_a = rwl_pkg::MULW'(rot_reg[rot_idx]);
                mul_b = rwl_pkg::MULW'(hist_rd);
            end
            ST_DEN:
            begin
                mul_a = rwl_pkg::MULW'(d_reg[k_reg]);
                mul_b = rwl_pkg::MULW'(d_reg[k_reg]);
            end
            ST_NUM:
            begin
                mul_a = rwl_pkg::MULW'(hist_rd);
                mul_b = rwl_pkg::MULW'(d_reg[k_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        acc_sum = acc_reg + rwl_pkg::ACCW'(prod_reg);
        rnd     = (acc_sum + rwl_pkg::ACCW'(rwl_pkg::ROT_HALF)) >>> rwl_pkg::ROT_FRAC;
        if ((&rnd[rwl_pkg::ACCW-1:rwl_pkg::VW-1]) || !(|rnd[rwl_pkg::ACCW-1:rwl_pkg::VW-1]))
        begin
            rot_sat = rnd[rwl_pkg::VW-1:0];
        end
        else
        begin
            rot_sat = rnd[rwl_pkg::ACCW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        n_mag = acc_sum[rwl_pkg::ACCW-1] ? rwl_pkg::ACCW'(-acc_sum) : rwl_pkg::ACCW'(acc_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            ph_reg      <= 1'b0;
            fit_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
            dreq_reg    <= '0;
            acc_reg     <= '0;
            for (int n = 0; n < rwl_pkg::HIST_N; n++)
            begin
                hist_reg[n] <= '0;
            end
            for (int n = 0; n < rwl_pkg::NP - 1; n++)
            begin
                step_reg[n] <= '0;
            end
            for (int n = 0; n < 3; n++)
            begin
                last_reg[n] <= '0;
            end
        end
        else
        begin
            // launch the divider on the last numerator product
            dreq_reg.start <= (state_reg == ST_NUM) && ph_reg && k_last;
            if (state_reg == ST_DONE && (!out_vld_reg || accel.ready))
            begin
                out_vld_reg <= 1'b1;
            end
            else if (accel.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (sample.valid)
                    begin
                        vin_reg[0] <= sample.vel_x;
                        vin_reg[1] <= sample.vel_y;
                        vin_reg[2] <= sample.vel_z;
                        for (int c = 0; c < 3; c++)
                        begin
                            rot_reg[c]     <= sample.rot_row0[16*c +: 16];
                            rot_reg[3 + c] <= sample.rot_row1[16*c +: 16];
                            rot_reg[6 + c] <= sample.rot_row2[16*c +: 16];
                        end
                        for (int n = 0; n < rwl_pkg::NP - 2; n++)
                        begin
                            step_reg[n] <= step_reg[n+1];
                        end
                        step_reg[rwl_pkg::NP-2] <= sample.time_step;
                        k_reg     <= rwl_pkg::KW'(rwl_pkg::NP - 1);
                        i_reg     <= '0;
                        j_reg     <= '0;
                        ph_reg    <= 1'b0;
                        acc_reg   <= '0;
                        state_reg <= ST_ROT;
                    end
                end
                ST_ROT:
                begin
                    ph_reg <= !ph_reg;
                    if (!ph_reg)
                    begin
                        prod_reg <= mul_a * mul_b;
                    end
                    else if (j_reg == 2'd2)
                    begin
                        // older entries move up in place, newest source read last
                        hist_reg[wr_idx] <= rot_sat;
                        acc_reg          <= '0;
                        j_reg            <= '0;
                        if (i_reg == 2'd2)
                        begin
                            i_reg <= '0;
                            if (k_reg == rwl_pkg::KW'(1))
                            begin
                                state_reg <= ST_LOAD;
                            end
                            else
                            begin
                                k_reg <= k_reg - rwl_pkg::KW'(1);
                            end
                        end
                        else
                        begin
                            i_reg <= i_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        acc_reg <= acc_sum;
                        j_reg   <= j_reg + 2'd1;
                    end
                end
                ST_LOAD:
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        hist_reg[c] <= vin_reg[c];
                    end
                    for (int n = 0; n < rwl_pkg::NP; n++)
                    begin
                        d_reg[n] <= d_c[n];
                    end
                    k_reg     <= '0;
                    ph_reg    <= 1'b0;
                    acc_reg   <= '0;
                    state_reg <= ST_DEN;
                end
                ST_DEN:
                begin
                    ph_reg <= !ph_reg;
                    if (!ph_reg)
                    begin
                        prod_reg <= mul_a * mul_b;
                    end
                    else if (k_last)
                    begin
                        den_reg <= rwl_pkg::ACCW'(acc_sum);
                        acc_reg <= '0;
                        k_reg   <= '0;
                        i_reg   <= '0;
                        if (acc_sum == '0)
                        begin
                            // no time spread: repeat the last estimate
                            fit_reg   <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_NUM;
                        end
                    end
                    else
                    begin
                        acc_reg <= acc_sum;
                        k_reg   <= k_reg + rwl_pkg::KW'(1);
                    end
                end
                ST_NUM:
                begin
                    ph_reg <= !ph_reg;
                    if (!ph_reg)
                    begin
                        prod_reg <= mul_a * mul_b;
                    end
                    else if (k_last)
                    begin
                        dmag_reg     <= n_mag;
                        dreq_reg.neg <= acc_sum[rwl_pkg::ACCW-1];
                        acc_reg      <= '0;
                        k_reg        <= '0;
                        state_reg    <= ST_DIVW;
                    end
                    else
                    begin
                        acc_reg <= acc_sum;
                        k_reg   <= k_reg + rwl_pkg::KW'(1);
                    end
                end
                ST_DIVW:
                begin
                    if (dres.done)
                    begin
                        last_reg[i_reg] <= dres.value;
                        if (i_reg == 2'd2)
                        begin
                            fit_reg   <= 1'b1;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 2'd1;
                            state_reg <= ST_NUM;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (!out_vld_reg || accel.ready)
                    begin
                        ax_reg    <= last_reg[0];
                        ay_reg    <= last_reg[1];
                        az_reg    <= last_reg[2];
                        ofit_reg  <= fit_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    rwl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq_reg),
        .mag   (dmag_reg),
        .den   (den_reg),
        .res   (dres)
    );

    assign sample.ready    = state_reg == ST_IDLE;
    assign accel.valid     = out_vld_reg;
    assign accel.acc_x     = ax_reg;
    assign accel.acc_y     = ay_reg;
    assign accel.acc_z     = az_reg;
    assign accel.fit_valid = ofit_reg;

    a_rot_src: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROT |-> k_reg != '0)
        else $error("rotation reads past the newest entry");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        dres.done |-> state_reg == ST_DIVW)
        else $error("divider result arrived outside the wait state");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !out_vld_reg) |=> out_vld_reg)
        else $error("finished result not loaded into an empty output register");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NUM |-> den_reg != '0)
        else $error("slope started with zero time spread");

endmodule

/* hw/rtl/rwl_div.sv */
// Restoring divider for the slope: |N| * NP * 2^20 / D, one quotient bit per cycle,
// saturated to the signed 32-bit range. Depends on rwl_pkg.
module rwl_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rwl_pkg::div_req_t        req,
    input  logic [rwl_pkg::ACCW-1:0] mag,
    input  logic [rwl_pkg::ACCW-1:0] den,
    output rwl_pkg::div_res_t        res
);

    typedef enum logic [1:0] {DV_IDLE, DV_CHK, DV_RUN, DV_FIN} dv_state_t;

    dv_state_t                      state_reg;
    logic [rwl_pkg::NUMW-1:0]       num_reg;
    logic [rwl_pkg::ACCW-1:0]       den_reg;
    logic [rwl_pkg::ACCW-1:0]       rem_reg;
    logic [rwl_pkg::VW-1:0]         qsh_reg;
    logic [4:0]                     cnt_reg;
    logic                           neg_reg;
    logic                           sat_reg;
    rwl_pkg::div_res_t              res_reg;

    logic [rwl_pkg::ACCW:0]         trial;
    logic                           ge;
    logic [rwl_pkg::CW-1:0]         num_hi;
    logic [rwl_pkg::VW-1:0]         lim;
    logic [rwl_pkg::VW-1:0]         q_sat;

    always_comb
    begin
        trial  = {rem_reg, qsh_reg[rwl_pkg::VW-1]};
        ge     = trial >= {1'b0, den_reg};
        num_hi = num_reg[rwl_pkg::NUMW-1:rwl_pkg::VW];
        lim    = neg_reg ? 32'h8000_0000 : 32'h7fff_ffff;
        q_sat  = (sat_reg || qsh_reg >= lim) ? lim : qsh_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= DV_IDLE;
            res_reg.done  <= 1'b0;
            res_reg.value <= '0;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            neg_reg       <= 1'b0;
        end
        else
        begin
            res_reg.done <= state_reg == DV_FIN;
            case (state_reg)
                DV_IDLE:
                begin
                    if (req.start)
                    begin
                        num_reg   <= rwl_pkg::NUMW'(rwl_pkg::NUMW'(mag)
                                     * rwl_pkg::NUMW'(rwl_pkg::NP)) << rwl_pkg::ACC_FRAC;
                        den_reg   <= den;
                        neg_reg   <= req.neg;
                        state_reg <= DV_CHK;
                    end
                end
                DV_CHK:
                begin
                    // quotient would need more than 32 bits: saturate
                    if (rwl_pkg::ACCW'(num_hi) >= den_reg)
                    begin
                        sat_reg   <= 1'b1;
                        state_reg <= DV_FIN;
                    end
                    else
                    begin
                        sat_reg   <= 1'b0;
                        rem_reg   <= rwl_pkg::ACCW'(num_hi);
                        qsh_reg   <= num_reg[rwl_pkg::VW-1:0];
                        cnt_reg   <= 5'd31;
                        state_reg <= DV_RUN;
                    end
                end
                DV_RUN:
                begin
                    rem_reg <= ge ? rwl_pkg::ACCW'(trial - {1'b0, den_reg})
                                  : trial[rwl_pkg::ACCW-1:0];
                    qsh_reg <= {qsh_reg[rwl_pkg::VW-2:0], ge};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        state_reg <= DV_FIN;
                    end
                end
                DV_FIN:
                begin
                    res_reg.value <= neg_reg ? -q_sat : q_sat;
                    state_reg     <= DV_IDLE;
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    assign res = res_reg;

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DV_RUN |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.done |=> !res_reg.done)
        else $error("divider done held longer than one cycle");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && state_reg != DV_IDLE) |-> 1'b0)
        else $error("divider started while busy");

endmodule

/* verif/tb_top.sv */
// Testbench for rotated_window_lsq_accel: drives velocity samples, predicts each
// acceleration estimate with a 128-bit integer model and checks every result.
// Depends on rwl_pkg, rwl_sample_if, rwl_accel_if and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int NP = rwl_pkg::NP;

    typedef struct {
        logic signed [31:0] vx, vy, vz;
        logic [47:0]        r0, r1, r2;
        logic [23:0]        dt;
    } sample_t;

    typedef struct {
        logic signed [31:0] ax, ay, az;
        logic               fv;
    } estimate_t;

    localparam int LIMIT_CYCLES = 3000000;

    logic clk;
    logic rst_n;

    rwl_sample_if sample ();
    rwl_accel_if  accel ();

    rotated_window_lsq_accel dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample.sink),
        .accel (accel.source)
    );

    sample_t   pending_samples[$];
    estimate_t expected_estimates[$];

    // predictor state
    logic signed [31:0] vel_hist[NP][3];
    logic [23:0]        step_hist[NP-1];
    logic signed [31:0] held_accel[3];

    int  errors = 0;
    int  cycle_count = 0;
    int  n_results = 0;
    int  n_fit_invalid = 0;
    int  n_saturated = 0;
    bit  stimulus_done = 1'b0;
    bit  quiet_phase;
    int  hold_off;

    function automatic logic signed [31:0] sat32(logic signed [127:0] x);
        if (x > 128'sd2147483647)
            return 32'sh7fffffff;
        if (x < -128'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic estimate_t predict_estimate(sample_t s);
        logic signed [15:0]  rot[3][3];
        logic [47:0]         rows[3];
        logic signed [31:0]  vin[3];
        logic signed [127:0] acc, num, den, q;
        logic signed [127:0] t[NP];
        logic signed [127:0] dv[NP];
        logic signed [127:0] sum_t;
        estimate_t           e;
        rows[0] = s.r0;
        rows[1] = s.r1;
        rows[2] = s.r2;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                rot[i][j] = rows[i][16*j +: 16];
        for (int k = NP - 1; k >= 1; k--)
            for (int i = 0; i < 3; i++)
            begin
                acc = 0;
                for (int j = 0; j < 3; j++)
                    acc += 128'(rot[j][i]) * 128'(vel_hist[k-1][j]);
                vel_hist[k][i] = sat32((acc + 8192) >>> 14);
            end
        vin[0] = s.vx;
        vin[1] = s.vy;
        vin[2] = s.vz;
        for (int i = 0; i < 3; i++)
            vel_hist[0][i] = vin[i];
        for (int k = 0; k < NP - 2; k++)
            step_hist[k] = step_hist[k+1];
        step_hist[NP-2] = s.dt;
        t[0] = 0;
        for (int k = 0; k < NP - 1; k++)
            t[k+1] = t[k] + 128'(step_hist[k]);
        sum_t = 0;
        for (int k = 0; k < NP; k++)
            sum_t += t[k];
        den = 0;
        for (int k = 0; k < NP; k++)
        begin
            dv[k] = NP * t[k] - sum_t;
            den += dv[k] * dv[k];
        end
        e.fv = (den != 0);
        if (e.fv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num = 0;
                for (int k = 0; k < NP; k++)
                    num += 128'(vel_hist[NP-1-k][i]) * dv[k];
                // quotient truncates toward zero
                q = (num * (128'sd1 <<< 20) * NP) / den;
                held_accel[i] = sat32(q);
            end
        end
        e.ax = held_accel[0];
        e.ay = held_accel[1];
        e.az = held_accel[2];
        return e;
    endfunction

    function automatic logic [47:0] rand_row();
        logic [15:0] c[3];
        for (int j = 0; j < 3; j++)
            case ($urandom_range(0, 3))
                0: c[j] = 16'h4000;
                1: c[j] = 16'hc000;
                2: c[j] = 16'($urandom_range(0, 4096)) - 16'd2048;
                default: c[j] = 16'($urandom);
            endcase
        return {c[2], c[1], c[0]};
    endfunction

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 20000000)) - 32'd10000000;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_sample(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                              logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
                              logic [23:0] dt);
        sample_t s;
        s.vx = vx;
        s.vy = vy;
        s.vz = vz;
        s.r0 = r0;
        s.r1 = r1;
        s.r2 = r2;
        s.dt = dt;
        pending_samples.push_back(s);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        logic [47:0] id0, id1, id2;
        logic [23:0] dt;
        id0 = 48'h0000_0000_4000;
        id1 = 48'h0000_4000_0000;
        id2 = 48'h4000_0000_0000;
        for (int i = 0; i < NP; i++)
            vel_hist[i] = '{0, 0, 0};
        for (int i = 0; i < NP - 1; i++)
            step_hist[i] = 0;
        held_accel = '{0, 0, 0};
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // zero time spread at start, then a ramp
        add_sample(0, 0, 0, id0, id1, id2, 0);
        add_sample(32'h10000, 32'hffff0000, 0, id0, id1, id2, 0);
        for (int i = 0; i < 5; i++)
            add_sample(32'h10000 * i, -32'sh20000 * i, 32'h7fffffff, id0, id1, id2, 24'h4000);
        // extremes: saturating slope, tiny and huge dt
        add_sample(32'h7fffffff, 32'h80000000, 32'h7fffffff, id0, id1, id2, 1);
        add_sample(32'h80000000, 32'h7fffffff, 32'h80000000, id0, id1, id2, 1);
        add_sample(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, id0, id1, id2, 24'hffffff);
        add_sample(32'h80000000, 32'h80000000, 32'h80000000, id0, id1, id2, 24'hffffff);
        // rotation overflow: non-orthogonal all -2.0 entries
        add_sample(32'h80000000, 32'h80000000, 32'h80000000,
                   48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 7);
        add_sample(32'h7fffffff, 1, 32'hffffffff,
                   48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 24'h800000);
        add_sample(5, 6, 7, 48'hffff_ffff_ffff, 48'h0, 48'hffff_ffff_ffff, 24'h555555);
        add_sample(1, 2, 3, 48'h0000_c000_0000, id0, id2, 24'haaaaaa);
        // four zero steps collapse the spread again
        for (int i = 0; i < 4; i++)
            add_sample(32'h1000 * i, 0, 0, id0, id1, id2, 0);
        add_sample(32'h1000, 0, 0, id0, id1, id2, 0);

        for (int n = 0; n < 1050; n++)
        begin
            case ($urandom_range(0, 9))
                0: dt = 0;
                1: dt = $urandom_range(0, 3);
                2: dt = 24'hffffff;
                default: dt = 24'($urandom);
            endcase
            if ($urandom_range(0, 2) == 0)
                add_sample(rand_vel(), rand_vel(), rand_vel(), id0, id1, id2, dt);
            else
                add_sample(rand_vel(), rand_vel(), rand_vel(), rand_row(), rand_row(),
                           rand_row(), dt);
        end
        stimulus_done = 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample.valid     <= 1'b0;
            sample.vel_x     <= '0;
            sample.vel_y     <= '0;
            sample.vel_z     <= '0;
            sample.rot_row0  <= '0;
            sample.rot_row1  <= '0;
            sample.rot_row2  <= '0;
            sample.time_step <= '0;
        end
        else if (!sample.valid || sample.ready)
        begin
            if (sample.valid)
                expected_estimates.push_back(predict_estimate(pending_samples.pop_front()));
            if (pending_samples.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 28))
            begin
                sample.valid     <= 1'b1;
                sample.vel_x     <= pending_samples[0].vx;
                sample.vel_y     <= pending_samples[0].vy;
                sample.vel_z     <= pending_samples[0].vz;
                sample.rot_row0  <= pending_samples[0].r0;
                sample.rot_row1  <= pending_samples[0].r1;
                sample.rot_row2  <= pending_samples[0].r2;
                sample.time_step <= pending_samples[0].dt;
            end
            else
                sample.valid <= 1'b0;
        end
    end

    // receiver stall pattern: long hold-off once, quiet stretch later
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel.ready <= 1'b0;
            hold_off    <= 0;
            quiet_phase <= 1'b0;
        end
        else
        begin
            quiet_phase <= (n_results >= 300 && n_results < 450);
            if (n_results == 30 && hold_off == 0)
                hold_off <= 2000;
            if (hold_off > 1)
            begin
                hold_off    <= hold_off - 1;
                accel.ready <= 1'b0;
            end
            else
            begin
                if (hold_off == 1)
                    hold_off <= -1;
                accel.ready <= quiet_phase || ($urandom_range(0, 99) >= 28);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        estimate_t e;
        if (rst_n && accel.valid && accel.ready)
        begin
            n_results <= n_results + 1;
            if (expected_estimates.size() == 0)
            begin
                $display("%0t: unexpected result acc=%h %h %h fit_valid=%b", $time,
                         accel.acc_x, accel.acc_y, accel.acc_z, accel.fit_valid);
                errors++;
            end
            else
            begin
                e = expected_estimates.pop_front();
                if (!e.fv)
                    n_fit_invalid++;
                if (e.ax == 32'sh7fffffff || e.ax == 32'sh80000000)
                    n_saturated++;
                if (accel.acc_x !== e.ax || accel.acc_y !== e.ay || accel.acc_z !== e.az
                    || accel.fit_valid !== e.fv)
                begin
                    $display("%0t: mismatch expected acc=%h %h %h fv=%b actual acc=%h %h %h fv=%b",
                             $time, e.ax, e.ay, e.az, e.fv,
                             accel.acc_x, accel.acc_y, accel.acc_z, accel.fit_valid);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (stimulus_done);
        while ((pending_samples.size() > 0 || sample.valid || expected_estimates.size() > 0)
               && cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout with %0d results outstanding", expected_estimates.size());
            $display("Verification failed");
        end
        else
        begin
            // extra results would show up within one transaction time
            repeat (500) @(posedge clk);
            $display("Checked %0d estimates: %0d with zero time spread, %0d saturated on x",
                     n_results, n_fit_invalid, n_saturated);
            if (errors == 0)
                $display("Verification passed");
            else
                $display("Verification failed");
        end
        $finish;
    end
endmodule
